>>> design/dbdf_pkg.sv
// shared types, widths and register codes for the detection box decode filter
`default_nettype none

package dbdf_pkg;

   localparam int MAX_CLASSES     = 80;
   localparam int VALUE_W         = 16;
   localparam int COL_W           = 7;
   localparam int CLASS_W         = 7;
   localparam int COORD_W         = 22;
   localparam int COUNT_W         = 17;
   localparam int SCORE_W         = 16;
   localparam int SCALE_SHIFT     = 13;
   // 2*center +/- size needs 18 magnitude bits plus sign
   localparam int DIFF_W          = VALUE_W + 3;
   localparam int PROD_W          = DIFF_W + VALUE_W + 1;

   localparam int BOX_COLS        = 4;
   localparam int OBJ_COL         = 4;
   localparam int FIRST_CLASS_COL = 5;

   localparam int ROWQ_DEPTH      = 4;
   localparam int ROWQ_PTR_W      = $clog2(ROWQ_DEPTH);
   localparam int ROWQ_CNT_W      = $clog2(ROWQ_DEPTH + 1);
   localparam int RSPQ_DEPTH      = 2;
   localparam int RSPQ_PTR_W      = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W      = $clog2(RSPQ_DEPTH + 1);

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BOXES   = 3'd4;

   localparam logic [15:0]      RST_SCORE_MIN   = 16'd16384;
   localparam logic [COL_W-1:0] RST_CLASS_COUNT = 7'd80;
   localparam logic [15:0]      RST_SCALE       = 16'd4096;
   localparam logic [15:0]      RST_MAX_BOXES   = 16'd30000;

   typedef struct packed {
      logic [SCORE_W-1:0] score_min;
      logic [COL_W-1:0]   class_count;
      logic [15:0]        scale_x;
      logic [15:0]        scale_y;
      logic [15:0]        max_boxes;
   } cfg_type;

   // one finished row handed from front to back
   typedef struct packed {
      logic               clear;
      logic [VALUE_W-1:0] cx;
      logic [VALUE_W-1:0] cy;
      logic [VALUE_W-1:0] w;
      logic [VALUE_W-1:0] h;
      logic [SCORE_W-1:0] obj;
      logic [SCORE_W-1:0] best;
      logic [CLASS_W-1:0] best_class;
   } row_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic [SCORE_W-1:0]        score;
      logic [CLASS_W-1:0]        class_label;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> design/dbdf_front.sv
// row front end: column tracking, box field capture and running class maximum
`default_nettype none

module dbdf_front
   import dbdf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               in_accept,
   input  wire logic [VALUE_W-1:0] in_value,
   input  wire logic               in_new_image,
   output logic                    row_valid,
   output row_word_type            row_word
);

   logic [COL_W-1:0]   column_ff, column_in;
   logic [VALUE_W-1:0] cx_ff, cx_in, cy_ff, cy_in, w_ff, w_in, h_ff, h_in;
   logic [SCORE_W-1:0] obj_ff, obj_in, best_ff, best_in;
   logic [CLASS_W-1:0] best_class_ff, best_class_in;
   logic               clear_pend_ff, clear_pend_in;
   logic [COL_W-1:0]   nc, last, col;
   logic               row_end;

   always_comb begin
      if (cfg.class_count == '0) begin
         nc = COL_W'(1);
      end else if (cfg.class_count > COL_W'(MAX_CLASSES)) begin
         nc = COL_W'(MAX_CLASSES);
      end else begin
         nc = cfg.class_count;
      end
      last = COL_W'(OBJ_COL) + nc;
   end

   always_comb begin
      col           = in_new_image ? '0 : column_ff;
      row_end       = (col >= last);
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      obj_in        = obj_ff;
      best_in       = best_ff;
      best_class_in = best_class_ff;
      if (col < COL_W'(BOX_COLS)) begin
         case (col[1:0])
            2'd0:    cx_in = in_value;
            2'd1:    cy_in = in_value;
            2'd2:    w_in  = in_value;
            2'd3:    h_in  = in_value;
            default: cx_in = in_value;
         endcase
      end else if (col == COL_W'(OBJ_COL)) begin
         obj_in = in_value;
      end else if (col == COL_W'(FIRST_CLASS_COL)) begin
         best_in       = in_value;
         best_class_in = '0;
      end else if (in_value > best_ff) begin
         best_in       = in_value;
         best_class_in = CLASS_W'(col - COL_W'(FIRST_CLASS_COL));
      end
      column_in     = row_end ? '0 : col + COL_W'(1);
      clear_pend_in = row_end ? 1'b0 : (clear_pend_ff | in_new_image);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         clear_pend_ff <= 1'b0;
      end else if (in_accept) begin
         column_ff     <= column_in;
         clear_pend_ff <= clear_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         cx_ff         <= cx_in;
         cy_ff         <= cy_in;
         w_ff          <= w_in;
         h_ff          <= h_in;
         obj_ff        <= obj_in;
         best_ff       <= best_in;
         best_class_ff <= best_class_in;
      end
   end

   assign row_valid           = in_accept & row_end;
   assign row_word.clear      = clear_pend_ff | in_new_image;
   assign row_word.cx         = cx_in;
   assign row_word.cy         = cy_in;
   assign row_word.w          = w_in;
   assign row_word.h          = h_in;
   assign row_word.obj        = obj_in;
   assign row_word.best       = best_in;
   assign row_word.best_class = best_class_in;

endmodule

`default_nettype wire

>>> design/dbdf_row_queue.sv
// small queue of finished rows between front and back
`default_nettype none

module dbdf_row_queue
   import dbdf_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire row_word_type wdata,
   output logic        full,
   input  wire logic   pop,
   output row_word_type rdata,
   output logic        empty
);

   row_word_type          mem [ROWQ_DEPTH];
   logic [ROWQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ROWQ_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == ROWQ_CNT_W'(ROWQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + ROWQ_CNT_W'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - ROWQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + ROWQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + ROWQ_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

>>> design/dbdf_back.sv
// back end: score, threshold and box limit, then corner scaling
`default_nettype none

module dbdf_back
   import dbdf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_empty,
   input  wire row_word_type q_word,
   output logic         q_pop,
   input  wire logic    out_full,
   output logic         out_push,
   output rsp_word_type out_word
);

   logic                     en;
   logic [COUNT_W-1:0]       count_ff, count_in, count_base, count_inc;
   logic                     limit_ff, limit_in, limit_base;
   logic [2*SCORE_W-1:0]     score_prod;
   logic [SCORE_W-1:0]       score;
   logic                     emit;
   logic signed [DIFF_W-1:0] twice_x, twice_y, size_w, size_h;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [DIFF_W-1:0] s1_dx1_ff, s1_dy1_ff, s1_dx2_ff, s1_dy2_ff;
   logic [SCORE_W-1:0]       s1_score_ff;
   logic [CLASS_W-1:0]       s1_class_ff;

   logic                     s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0] px1, py1, px2, py2;
   rsp_word_type             s2_word_ff;

   assign en    = ~(s2_valid_ff & out_full);
   assign q_pop = en & ~q_empty;

   // score and limit decision
   always_comb begin
      count_base = q_word.clear ? '0 : count_ff;
      limit_base = q_word.clear ? 1'b0 : limit_ff;
      score_prod = q_word.obj * q_word.best;
      score      = score_prod[2*SCORE_W-1:SCORE_W];
      emit       = (q_word.obj >= cfg.score_min) &&
                   (score >= cfg.score_min) && !limit_base;
      count_inc  = count_base + COUNT_W'(1);
      count_in   = emit ? count_inc : count_base;
      limit_in   = emit ? (count_inc > {1'b0, cfg.max_boxes}) : limit_base;
      twice_x    = $signed({2'b00, q_word.cx, 1'b0});
      twice_y    = $signed({2'b00, q_word.cy, 1'b0});
      size_w     = $signed({3'b000, q_word.w});
      size_h     = $signed({3'b000, q_word.h});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= 1'b0;
      end else if (q_pop) begin
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

   assign s1_valid_in = en ? (q_pop & emit) : s1_valid_ff;
   assign s2_valid_in = en ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx1_ff   <= twice_x - size_w;
         s1_dx2_ff   <= twice_x + size_w;
         s1_dy1_ff   <= twice_y - size_h;
         s1_dy2_ff   <= twice_y + size_h;
         s1_score_ff <= score;
         s1_class_ff <= q_word.best_class;
      end
   end

   // scale multiply, floor shift by taking the upper bits
   always_comb begin
      px1 = PROD_W'(s1_dx1_ff) * $signed({1'b0, cfg.scale_x});
      px2 = PROD_W'(s1_dx2_ff) * $signed({1'b0, cfg.scale_x});
      py1 = PROD_W'(s1_dy1_ff) * $signed({1'b0, cfg.scale_y});
      py2 = PROD_W'(s1_dy2_ff) * $signed({1'b0, cfg.scale_y});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_word_ff.x1          <= px1[SCALE_SHIFT+COORD_W-1:SCALE_SHIFT];
         s2_word_ff.y1          <= py1[SCALE_SHIFT+COORD_W-1:SCALE_SHIFT];
         s2_word_ff.x2          <= px2[SCALE_SHIFT+COORD_W-1:SCALE_SHIFT];
         s2_word_ff.y2          <= py2[SCALE_SHIFT+COORD_W-1:SCALE_SHIFT];
         s2_word_ff.score       <= s1_score_ff;
         s2_word_ff.class_label <= s1_class_ff;
      end
   end

   assign out_push = s2_valid_ff & ~out_full;
   assign out_word = s2_word_ff;

endmodule

`default_nettype wire

>>> design/dbdf_rsp_queue.sv
// output queue holding finished boxes until popped
`default_nettype none

module dbdf_rsp_queue
   import dbdf_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire rsp_word_type wdata,
   output logic        full,
   input  wire logic   pop,
   output rsp_word_type rdata,
   output logic        empty
);

   rsp_word_type          mem [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSPQ_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == RSPQ_CNT_W'(RSPQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + RSPQ_CNT_W'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - RSPQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + RSPQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSPQ_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

>>> design/detection_box_decode_filter_top.sv
// top level of the detection box decode filter: registers, front, queues and back
`default_nettype none

// detection box decode filter. takes detector output rows one 16-bit word per
// cycle (center x, center y, width, height in q12.4, object confidence, then
// one class score per class in q0.16) and pushes one corner box per row whose
// object confidence and combined score both meet the score threshold; once the
// per-image box count exceeds max_boxes no further box is emitted until
// req_new_image marks the first word of the next image.
// a word is taken every cycle: req_full rises only when the four-entry row
// queue between front and back is full, which needs the output side to stall.
// after the row's last word a box passes the row queue, score stage, scale multiply
// stage and result queue before rsp_empty falls. coordinates are signed q.4 pixels
// with floor rounding; registers are written through csr_we / csr_index /
// csr_wdata and must only change while the block is idle

module detection_box_decode_filter_top
   import dbdf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire logic [VALUE_W-1:0]        req_value,
   input  wire logic                      req_new_image,

   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic signed [COORD_W-1:0]      rsp_x1,
   output logic signed [COORD_W-1:0]      rsp_y1,
   output logic signed [COORD_W-1:0]      rsp_x2,
   output logic signed [COORD_W-1:0]      rsp_y2,
   output logic [SCORE_W-1:0]             rsp_score,
   output logic [CLASS_W-1:0]             rsp_class_label,

   input  wire logic                      csr_we,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [15:0]               csr_wdata
);

   cfg_type      cfg_ff;
   logic         in_accept;
   logic         row_valid;
   row_word_type row_word;
   logic         rowq_full, rowq_empty, rowq_pop;
   row_word_type rowq_word;
   logic         rspq_full, rspq_push;
   rsp_word_type back_word, rspq_word;

   // configuration registers, writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_min   <= RST_SCORE_MIN;
         cfg_ff.class_count <= RST_CLASS_COUNT;
         cfg_ff.scale_x     <= RST_SCALE;
         cfg_ff.scale_y     <= RST_SCALE;
         cfg_ff.max_boxes   <= RST_MAX_BOXES;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCORE_MIN:   cfg_ff.score_min   <= csr_wdata;
            CSR_CLASS_COUNT: cfg_ff.class_count <= csr_wdata[COL_W-1:0];
            CSR_SCALE_X:     cfg_ff.scale_x     <= csr_wdata;
            CSR_SCALE_Y:     cfg_ff.scale_y     <= csr_wdata;
            CSR_MAX_BOXES:   cfg_ff.max_boxes   <= csr_wdata;
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   // input word taken whenever the row queue has room
   assign req_full  = rowq_full;
   assign in_accept = req_push & ~rowq_full;

   // front: column counter, field capture, running class max
   dbdf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_accept    (in_accept),
      .in_value     (req_value),
      .in_new_image (req_new_image),
      .row_valid    (row_valid),
      .row_word     (row_word)
   );

   // decouples row capture from the scoring pipeline
   dbdf_row_queue u_row_queue (
      .clock (clock),
      .reset (reset),
      .push  (row_valid),
      .wdata (row_word),
      .full  (rowq_full),
      .pop   (rowq_pop),
      .rdata (rowq_word),
      .empty (rowq_empty)
   );

   // back: score, threshold, box limit, corner scaling
   dbdf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (rowq_empty),
      .q_word   (rowq_word),
      .q_pop    (rowq_pop),
      .out_full (rspq_full),
      .out_push (rspq_push),
      .out_word (back_word)
   );

   // result queue toward the consumer
   dbdf_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rspq_push),
      .wdata (back_word),
      .full  (rspq_full),
      .pop   (rsp_pop),
      .rdata (rspq_word),
      .empty (rsp_empty)
   );

   assign rsp_x1          = rspq_word.x1;
   assign rsp_y1          = rspq_word.y1;
   assign rsp_x2          = rspq_word.x2;
   assign rsp_y2          = rspq_word.y2;
   assign rsp_score       = rspq_word.score;
   assign rsp_class_label = rspq_word.class_label;

endmodule

`default_nettype wire

>>> design/dbdf_checker.sv
// port-level checks for the detection box decode filter, bound to the top level
`default_nettype none

module dbdf_checker
   import dbdf_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_empty,
   input wire logic                 rsp_pop,
   input wire logic [COORD_W-1:0]   rsp_x1,
   input wire logic [COORD_W-1:0]   rsp_y1,
   input wire logic [COORD_W-1:0]   rsp_x2,
   input wire logic [COORD_W-1:0]   rsp_y2,
   input wire logic [SCORE_W-1:0]   rsp_score,
   input wire logic [CLASS_W-1:0]   rsp_class_label
);

   // nothing waits right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // width and scale are unsigned, so left edge never passes right edge
   a_x_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ($signed(rsp_x1) <= $signed(rsp_x2)))
      else $error("x1 above x2");

   a_y_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ($signed(rsp_y1) <= $signed(rsp_y2)))
      else $error("y1 above y2");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_class_label < CLASS_W'(MAX_CLASSES)))
      else $error("class label out of range");

   // a waiting word is held until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_x1) &&
                                    $stable(rsp_score) && $stable(rsp_class_label)))
      else $error("result word changed while waiting");

endmodule

bind detection_box_decode_filter_top dbdf_checker u_dbdf_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
// self-checking testbench for the detection box decode filter top level
`default_nettype none

module tb_top
   import dbdf_pkg::*;
();

   localparam int RESET_CYCLES   = 6;
   localparam int DRAIN_CYCLES   = 12;      // row queue, score and scale stages plus margin
   localparam int HOLD_CYCLES    = 200;     // long receiver hold-off to back the block up
   localparam int CYCLE_LIMIT    = 300000;
   localparam int RANDOM_PHASES  = 16;
   localparam int PRESSURE_PHASE = 2;
   localparam int PHASE_WORDS    = 40;
   localparam int PRESSURE_WORDS = 100;

   typedef enum int {
      FLOW_STEADY,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   // predicts the boxes for every accepted word and checks the popped ones in order
   class box_predictor;
      cfg_type              cfg;
      logic [COL_W-1:0]     column;
      logic [VALUE_W-1:0]   box_fields [BOX_COLS];
      logic [SCORE_W-1:0]   object_conf;
      logic [SCORE_W-1:0]   best_score;
      logic [CLASS_W-1:0]   best_class;
      logic [COUNT_W-1:0]   box_count;
      logic                 limit_hit;
      rsp_word_type         expected_boxes [$];
      int                   failures;

      function new();
         cfg.score_min   = RST_SCORE_MIN;
         cfg.class_count = RST_CLASS_COUNT;
         cfg.scale_x     = RST_SCALE;
         cfg.scale_y     = RST_SCALE;
         cfg.max_boxes   = RST_MAX_BOXES;
         column      = '0;
         object_conf = '0;
         best_score  = '0;
         best_class  = '0;
         box_count   = '0;
         limit_hit   = 1'b0;
         failures    = 0;
         foreach (box_fields[i]) box_fields[i] = '0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
         case (idx)
            CSR_SCORE_MIN:   cfg.score_min   = data;
            CSR_CLASS_COUNT: cfg.class_count = data[COL_W-1:0];
            CSR_SCALE_X:     cfg.scale_x     = data;
            CSR_SCALE_Y:     cfg.scale_y     = data;
            CSR_MAX_BOXES:   cfg.max_boxes   = data;
            default: ;
         endcase
      endfunction

      // (2*center -/+ span) * scale, floor-shifted to q.4 pixels
      function logic signed [COORD_W-1:0] corner(logic [15:0] center, logic [15:0] span,
                                                 bit upper, logic [15:0] scale);
         longint reach;
         longint scaled;
         reach  = 2 * longint'(center);
         reach  = upper ? reach + longint'(span) : reach - longint'(span);
         scaled = (reach * longint'(scale)) >>> SCALE_SHIFT;
         return scaled[COORD_W-1:0];
      endfunction

      function void note_word(logic [VALUE_W-1:0] v, logic first_of_image);
         int               classes;
         int               last_col;
         int               col;
         logic [31:0]      product;
         logic [SCORE_W-1:0] score;
         rsp_word_type     box;
         classes = cfg.class_count;
         if (classes < 1) classes = 1;
         if (classes > MAX_CLASSES) classes = MAX_CLASSES;
         last_col = FIRST_CLASS_COL + classes - 1;
         if (first_of_image) begin
            column    = '0;
            box_count = '0;
            limit_hit = 1'b0;
         end
         col = column;
         if (col < BOX_COLS) begin
            box_fields[col] = v;
         end else if (col == OBJ_COL) begin
            object_conf = v;
         end else if (col == FIRST_CLASS_COL) begin
            best_score = v;
            best_class = '0;
         end else if (v > best_score) begin
            best_score = v;
            best_class = CLASS_W'(col - FIRST_CLASS_COL);
         end
         if (col < last_col) begin
            column = COL_W'(col + 1);
            return;
         end
         column  = '0;
         product = {16'b0, object_conf} * {16'b0, best_score};
         score   = product[31:16];
         if (object_conf < cfg.score_min || score < cfg.score_min || limit_hit)
            return;
         box.x1 = corner(box_fields[0], box_fields[2], 1'b0, cfg.scale_x);
         box.y1 = corner(box_fields[1], box_fields[3], 1'b0, cfg.scale_y);
         box.x2 = corner(box_fields[0], box_fields[2], 1'b1, cfg.scale_x);
         box.y2 = corner(box_fields[1], box_fields[3], 1'b1, cfg.scale_y);
         box.score       = score;
         box.class_label = best_class;
         expected_boxes.insert(expected_boxes.size(), box);
         box_count = box_count + 1'b1;
         if (box_count > {1'b0, cfg.max_boxes}) limit_hit = 1'b1;
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] seen);
         if (seen !== want) begin
            $error("box %0s expected %0d got %0d", name, want, seen);
            failures++;
         end
      endfunction

      function void check_box(rsp_word_type seen);
         rsp_word_type want;
         if (expected_boxes.size() == 0) begin
            $error("box popped with none expected: x1 %0d y1 %0d score %0d class %0d",
                   seen.x1, seen.y1, seen.score, seen.class_label);
            failures++;
            return;
         end
         want = expected_boxes.pop_front();
         compare_field("x1", want.x1, seen.x1);
         compare_field("y1", want.y1, seen.y1);
         compare_field("x2", want.x2, seen.x2);
         compare_field("y2", want.y2, seen.y2);
         compare_field("score", want.score, seen.score);
         compare_field("class_label", want.class_label, seen.class_label);
      endfunction

      function int pending();
         return expected_boxes.size();
      endfunction
   endclass

   // dut connections, all inputs known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [VALUE_W-1:0]        req_value = '0;
   logic                      req_new_image = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic signed [COORD_W-1:0] rsp_x1;
   logic signed [COORD_W-1:0] rsp_y1;
   logic signed [COORD_W-1:0] rsp_x2;
   logic signed [COORD_W-1:0] rsp_y2;
   logic [SCORE_W-1:0]        rsp_score;
   logic [CLASS_W-1:0]        rsp_class_label;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [15:0]               csr_wdata = '0;

   box_predictor   boxes = new();
   flow_mode_type  traffic_mode = FLOW_STEADY;
   logic           hold_request = 1'b0;
   int             hold_left = 0;
   int             cycle_count = 0;
   int             row_classes = MAX_CLASSES;   // words per row minus five, as the block sees it
   rsp_word_type   popped;

   detection_box_decode_filter_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_value       (req_value),
      .req_new_image   (req_new_image),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_x1          (rsp_x1),
      .rsp_y1          (rsp_y1),
      .rsp_x2          (rsp_x2),
      .rsp_y2          (rsp_y2),
      .rsp_score       (rsp_score),
      .rsp_class_label (rsp_class_label),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 12 unit clock, high half then low half
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit roll(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // gap and stall odds for the current traffic phase
   function automatic int send_gap_pct();
      case (traffic_mode)
         FLOW_SENDER_GAPS: return 45;
         FLOW_BOTH:        return 23;
         default:          return 0;
      endcase
   endfunction

   function automatic int stall_pct();
      case (traffic_mode)
         FLOW_RECEIVER_STALLS: return 45;
         FLOW_BOTH:            return 23;
         default:              return 0;
      endcase
   endfunction

   // receiver: pop decided at the falling edge, long hold-off counted here
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !roll(stall_pct());
      end
   end

   // a box word moves on a rising edge with pop high and empty low
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         popped.x1          = rsp_x1;
         popped.y1          = rsp_y1;
         popped.x2          = rsp_x2;
         popped.y2          = rsp_y2;
         popped.score       = rsp_score;
         popped.class_label = rsp_class_label;
         boxes.check_box(popped);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL detection_box_decode_filter_top");
         $finish;
      end
   end

   // offer one word from a falling edge until it is taken, return at a falling edge
   task automatic push_word(input logic [VALUE_W-1:0] v, input logic first_of_image);
      while (roll(send_gap_pct())) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_value     <= v;
      req_new_image <= first_of_image;
      do @(posedge clock); while (req_full);
      boxes.note_word(v, first_of_image);
      @(negedge clock);
   endtask

   // a fixed run of words, new image flag on the first one only
   task automatic push_list(input logic [VALUE_W-1:0] words [$], input logic first_of_image);
      foreach (words[i]) push_word(words[i], first_of_image && i == 0);
   endtask

   // drop push and wait until every predicted box has been popped
   task automatic wait_idle();
      req_push <= 1'b0;
      while (boxes.pending() != 0) @(posedge clock);
      // rows that make no box may still be in the pipe
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      boxes.set_register(idx, data);
      @(negedge clock);
   endtask

   task automatic write_all(input logic [15:0] thr, input logic [15:0] classes,
                            input logic [15:0] sx, input logic [15:0] sy,
                            input logic [15:0] limit);
      write_reg(CSR_SCORE_MIN, thr);
      write_reg(CSR_CLASS_COUNT, classes);
      write_reg(CSR_SCALE_X, sx);
      write_reg(CSR_SCALE_Y, sy);
      write_reg(CSR_MAX_BOXES, limit);
      csr_we <= 1'b0;
      @(negedge clock);
      row_classes = classes[COL_W-1:0];
      if (row_classes < 1) row_classes = 1;
      if (row_classes > MAX_CLASSES) row_classes = MAX_CLASSES;
   endtask

   // value pickers, biased toward extremes and toward confident rows
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_conf();
      case ($urandom_range(0, 9))
         0:          return 16'h0000;
         1:          return 16'hFFFF;
         2, 3, 4, 5: return 16'($urandom_range(16'hB000, 16'hFFFF));
         default:    return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_threshold();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3, 4: return 16'($urandom_range(0, 16'h6000));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(0, 5))
         0:       return 16'h0001;
         1:       return 16'hFFFF;
         2:       return 16'h1000;
         default: return 16'($urandom_range(1, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [15:0] pick_max_boxes();
      case ($urandom_range(0, 7))
         0:          return 16'h0000;
         1:          return 16'hFFFF;
         2, 3, 4, 5: return 16'($urandom_range(0, 4));
         default:    return 16'($urandom);
      endcase
   endfunction

   // one row, or now and then a short run of stray words that breaks the row framing
   task automatic send_random_row(input bit start_image, output int sent);
      int n;
      sent = 0;
      if (roll(5)) begin
         n = $urandom_range(1, 4);
         repeat (n) push_word(16'($urandom), roll(10));
         sent = n;
         return;
      end
      for (int col = 0; col < FIRST_CLASS_COL + row_classes; col++) begin
         push_word(col < BOX_COLS ? pick_coord() : pick_conf(), start_image && col == 0);
         sent++;
      end
   endtask

   initial begin
      logic [VALUE_W-1:0] words [$];
      int                 phase_words;
      int                 budget;
      int                 sent;
      logic [15:0]        thr;
      logic [15:0]        classes;
      logic [15:0]        sx;
      logic [15:0]        sy;
      logic [15:0]        limit;

      // synchronous reset, once
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extreme coordinates and scales, box limit of zero, one class per row
      write_all(16'h0000, 16'd1, 16'hFFFF, 16'h0001, 16'h0000);
      words = {16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      push_list(words, 1'b1);
      // limit already passed, this box is dropped
      words = {16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF};
      push_list(words, 1'b0);
      // partial row cut short by a new image, which also clears the limit
      words = {16'h1234, 16'h5678, 16'h9ABC};
      push_list(words, 1'b0);
      words = {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
      push_list(words, 1'b1);
      wait_idle();

      // class tie keeps the earlier class, zero x scale
      write_all(16'h4000, 16'd3, 16'h0000, 16'h1000, 16'hFFFF);
      words = {16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'hFFFF,
               16'h9000, 16'hA000, 16'hA000};
      push_list(words, 1'b1);
      // leave a row open, then shrink the class count under it
      words = {16'h0100, 16'h0200, 16'h0040, 16'h0080, 16'hFFFF, 16'h8000, 16'h7000};
      push_list(words, 1'b0);
      wait_idle();
      write_all(16'h4000, 16'd1, 16'h1000, 16'h1000, 16'hFFFF);
      words = {16'hFFFF};
      push_list(words, 1'b0);
      wait_idle();

      // random phases, traffic pattern rotating with the phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         thr     = pick_threshold();
         classes = 16'($urandom_range(1, 6));
         sx      = pick_scale();
         sy      = pick_scale();
         limit   = pick_max_boxes();
         budget  = PHASE_WORDS;
         traffic_mode = flow_mode_type'(p % 4);
         case (p)
            5:  classes = 16'd0;
            9:  classes = 16'd127;
            13: classes = 16'(MAX_CLASSES);
            14: classes = 16'($urandom_range(7, 20));
            default: ;
         endcase
         if (p == 7) sx = 16'h0000;
         if (p == 11) sy = 16'h0000;
         if (p == PRESSURE_PHASE) begin
            // every row makes a box and the receiver sits still, so the block fills up
            thr          = 16'h0000;
            classes      = 16'd1;
            limit        = 16'hFFFF;
            budget       = PRESSURE_WORDS;
            traffic_mode = FLOW_STEADY;
         end
         write_all(thr, classes, sx, sy, limit);
         if (p == PRESSURE_PHASE) hold_request = 1'b1;

         phase_words = 0;
         while (phase_words < budget) begin
            send_random_row(phase_words == 0 || roll(20), sent);
            phase_words += sent;
         end
         // some phases stop in the middle of a row so the next settings meet it
         if (roll(50)) begin
            sent = $urandom_range(1, 4);
            repeat (sent) push_word(pick_conf(), 1'b0);
         end
         wait_idle();
      end

      // drain with the receiver always ready
      traffic_mode = FLOW_STEADY;
      wait_idle();
      if (boxes.failures == 0)
         $display("PASS detection_box_decode_filter_top");
      else
         $display("FAIL detection_box_decode_filter_top");
      $finish;
   end

endmodule

`default_nettype wire

>>> detection_box_decode_filter_top.f
design/dbdf_pkg.sv
design/dbdf_front.sv
design/dbdf_row_queue.sv
design/dbdf_back.sv
design/dbdf_rsp_queue.sv
design/detection_box_decode_filter_top.sv
design/dbdf_checker.sv
bench/tb_top.sv
